/* src/ate_pkg.sv */
// Shared types, constants and helper functions for the ANSI truecolor encoder.
// No dependencies; every other file in the block imports this package.
package ate_pkg;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Fixed-point luma weights (16 fractional bits).
  localparam logic [15:0] LUMA_WR = 16'd19589;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;

  // Highest ramp index.
  localparam logic [3:0] RAMP_MAX = 4'd14;

  // Byte codes used in the stream.
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_THREE   = 8'h33;
  localparam logic [7:0] CH_FOUR    = 8'h34;
  localparam logic [7:0] CH_EIGHT   = 8'h38;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_M       = 8'h6D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Three decimal digits of one channel.
  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  // One classified pixel, as handed from the front part to the back part.
  typedef struct packed {
    digits_t    red;
    digits_t    green;
    digits_t    blue;
    logic [7:0] glyph;
    logic       background;
    logic       row_end;
  } pixel_rec_t;

  // Queue status seen by the front part.
  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  // Brightness ramp " .,:;iltfLCG08@".
  function automatic logic [7:0] ramp_glyph(input logic [3:0] idx);
    logic [7:0] g;
    case (idx)
      4'd0:    g = 8'h20;
      4'd1:    g = 8'h2E;
      4'd2:    g = 8'h2C;
      4'd3:    g = 8'h3A;
      4'd4:    g = 8'h3B;
      4'd5:    g = 8'h69;
      4'd6:    g = 8'h6C;
      4'd7:    g = 8'h74;
      4'd8:    g = 8'h66;
      4'd9:    g = 8'h4C;
      4'd10:   g = 8'h43;
      4'd11:   g = 8'h47;
      4'd12:   g = 8'h30;
      4'd13:   g = 8'h38;
      default: g = 8'h40;
    endcase
    return g;
  endfunction

  // Splits an 8-bit value into three decimal digits without a divider.
  function automatic digits_t to_digits(input logic [7:0] v);
    digits_t    d;
    logic [7:0] rem;
    logic [13:0] scaled;
    logic [7:0] tens_x10;
    if (v >= 8'd200) begin
      d.hundreds = 4'd2;
      rem        = v - 8'd200;
    end else if (v >= 8'd100) begin
      d.hundreds = 4'd1;
      rem        = v - 8'd100;
    end else begin
      d.hundreds = 4'd0;
      rem        = v;
    end
    // rem < 100, so rem * 103 / 1024 is the exact tens digit.
    scaled   = {6'd0, rem} * 14'd103;
    d.tens   = scaled[13:10];
    tens_x10 = {4'd0, d.tens} * 8'd10;
    d.units  = 4'((rem - tens_x10));
    return d;
  endfunction

endpackage

/* src/ate_front.sv */
// Front part: takes pixels, computes luma, glyph and decimal digits, and
// pushes one record per pixel into the queue. Depends on ate_pkg.
module ate_front import ate_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_data,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  input  logic          row_end,
  input  queue_status_t qstat,
  output logic          rec_push,
  output pixel_rec_t    rec
);

  logic        background;
  logic        accept;

  // Stage one: weighted products and digit split.
  logic        v1;
  logic [22:0] prod_r;
  logic [23:0] prod_g;
  logic [20:0] prod_b;
  digits_t     dig_r;
  digits_t     dig_g;
  digits_t     dig_b;
  logic        bg1;
  logic        row_end1;

  // Stage two: luma sum and ramp lookup.
  logic [23:0] luma_sum;
  logic [7:0]  luma;
  logic [11:0] idx_scaled;
  logic [3:0]  idx;
  logic [QCNT_W+1:0] committed;

  // Space in the queue is reserved for every pixel still in the pipeline.
  assign committed = {2'd0, qstat.count} + {{(QCNT_W+1){1'b0}}, v1}
                   + {{(QCNT_W+1){1'b0}}, rec_push};
  assign full      = committed >= (QCNT_W+2)'(QUEUE_DEPTH);
  assign accept    = push && !full;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      background <= 1'b0;
    end else if (cfg_write) begin
      background <= cfg_data;
    end
  end

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    prod_r   <= 23'({15'd0, red}   * {8'd0, LUMA_WR});
    prod_g   <= {8'd0, green} * {8'd0, LUMA_WG};
    prod_b   <= 21'({16'd0, blue}  * {8'd0, LUMA_WB});
    dig_r    <= to_digits(red);
    dig_g    <= to_digits(green);
    dig_b    <= to_digits(blue);
    bg1      <= background;
    row_end1 <= row_end;
  end

  // Luma and ramp index; the index never exceeds 13 but is clamped anyway.
  always_comb begin
    luma_sum   = {1'b0, prod_r} + prod_g + {3'd0, prod_b};
    luma       = luma_sum[23:16];
    idx_scaled = {4'd0, luma} * 12'd14;
    idx        = (idx_scaled[11:8] > RAMP_MAX) ? RAMP_MAX : idx_scaled[11:8];
  end

  // Stage two registers feed the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_push <= 1'b0;
    end else begin
      rec_push <= v1;
    end
    rec.red        <= dig_r;
    rec.green      <= dig_g;
    rec.blue       <= dig_b;
    rec.glyph      <= bg1 ? CH_SPACE : ramp_glyph(idx);
    rec.background <= bg1;
    rec.row_end    <= row_end1;
  end

endmodule

/* src/ate_queue.sv */
// Short register queue of pixel records between the front and back parts.
// Depends on ate_pkg.
module ate_queue import ate_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  pixel_rec_t    wr_rec,
  input  logic          rd_en,
  output pixel_rec_t    head,
  output logic          head_valid,
  output queue_status_t qstat
);

  pixel_rec_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head        = entries[rd_ptr];
  assign head_valid  = count != '0;
  assign qstat.count = count;

  // Storage writes.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  // Pointers and fill count. The front never writes when the queue is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/ate_back.sv */
// Back part: walks the byte sequence of the queue head record and loads one
// byte a cycle into the output register while it is empty or popped. Depends on ate_pkg.
module ate_back import ate_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  pixel_rec_t head,
  input  logic       head_valid,
  output logic       head_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last
);

  typedef enum logic [4:0] {
    P_ESC, P_LBRACK, P_LAYER, P_EIGHT, P_SEMI0, P_TWO, P_SEMI1,
    P_R2, P_R1, P_R0, P_SEMI2,
    P_G2, P_G1, P_G0, P_SEMI3,
    P_B2, P_B1, P_B0, P_M,
    P_GLYPH,
    P_RST_ESC, P_RST_LBRACK, P_RST_ZERO, P_RST_M, P_NL
  } pos_t;

  pos_t       pos;
  logic       out_valid;
  logic       load;
  logic       is_last;
  logic [7:0] byte_now;

  // Byte for the current position.
  always_comb begin
    unique case (pos)
      P_ESC:        byte_now = CH_ESC;
      P_LBRACK:     byte_now = CH_LBRACK;
      P_LAYER:      byte_now = head.background ? CH_FOUR : CH_THREE;
      P_EIGHT:      byte_now = CH_EIGHT;
      P_TWO:        byte_now = CH_TWO;
      P_R2:         byte_now = {4'h3, head.red.hundreds};
      P_R1:         byte_now = {4'h3, head.red.tens};
      P_R0:         byte_now = {4'h3, head.red.units};
      P_G2:         byte_now = {4'h3, head.green.hundreds};
      P_G1:         byte_now = {4'h3, head.green.tens};
      P_G0:         byte_now = {4'h3, head.green.units};
      P_B2:         byte_now = {4'h3, head.blue.hundreds};
      P_B1:         byte_now = {4'h3, head.blue.tens};
      P_B0:         byte_now = {4'h3, head.blue.units};
      P_M:          byte_now = CH_M;
      P_GLYPH:      byte_now = head.glyph;
      P_RST_ESC:    byte_now = CH_ESC;
      P_RST_LBRACK: byte_now = CH_LBRACK;
      P_RST_ZERO:   byte_now = CH_ZERO;
      P_RST_M:      byte_now = CH_M;
      P_NL:         byte_now = CH_NEWLINE;
      default:      byte_now = CH_SEMI;
    endcase
  end

  // The glyph ends a pixel unless a row reset follows it.
  assign is_last  = (pos == P_GLYPH && !head.row_end) || pos == P_NL;
  assign load     = head_valid && (!out_valid || pop);
  assign head_pop = load && is_last;
  assign empty    = !out_valid;

  // Sequencer position and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= P_ESC;
      out_valid <= 1'b0;
    end else if (load) begin
      out_byte  <= byte_now;
      last      <= is_last;
      out_valid <= 1'b1;
      pos       <= is_last ? P_ESC : pos_t'(pos + 5'd1);
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* src/pixel_to_ansi_truecolor_encoder.sv */
// Top level of the pixel to ANSI 24-bit color encoder.
// Depends on ate_pkg, ate_front, ate_queue and ate_back.
//
//   channel  handshake        payload
//   config   cfg_write        cfg_data (background mode)
//   pixels   push / full      red, green, blue, row_end
//   bytes    pop / empty      out_byte, last
//
// Each pixel yields 20 bytes, or 25 at a row end, one byte per cycle from
// the back sequencer while bytes are popped, so the output limits sustained input.
// A pixel passes the stage one and stage two front registers before it reaches the queue.
// Pixels are taken every cycle while the four-entry queue has room.
// Reset is synchronous and clears the mode, the queue and the sequencer.
// A stalled pop holds the current byte; the front keeps filling the queue.
module pixel_to_ansi_truecolor_encoder import ate_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       row_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last
);

  queue_status_t qstat;
  logic          rec_push;
  pixel_rec_t    rec;
  pixel_rec_t    head;
  logic          head_valid;
  logic          head_pop;

  // Classification pipeline.
  ate_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .row_end   (row_end),
    .qstat     (qstat),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  // Decoupling queue.
  ate_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (rec_push),
    .wr_rec     (rec),
    .rd_en      (head_pop),
    .head       (head),
    .head_valid (head_valid),
    .qstat      (qstat)
  );

  // Byte sequencer.
  ate_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .last       (last)
  );

endmodule
